FILE: rtl/twa_pkg.sv
// Package for the tumbling window averager: payload structs, constants,
// and the queue entry type shared by front and back. No dependencies.
`timescale 1ns / 1ps
package twa_pkg;
    localparam int MAX_WIN   = 8;
    localparam int NUM_STR   = 4;
    localparam int WIN_W     = $clog2(MAX_WIN);
    localparam int STR_W     = 2;
    localparam int AVAL_W    = 3;
    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    localparam logic [0:0] REG_LEN = 1'b0;
    localparam logic [0:0] REG_ACT = 1'b1;

    localparam logic KIND_AVG  = 1'b0;
    localparam logic KIND_DROP = 1'b1;

    typedef struct packed {
        logic [1:0]  stream_id;
        logic [47:0] event_time;
        logic signed [31:0] sample;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [1:0]  out_stream;
        logic [47:0] window_begin;
        logic [47:0] window_end;
        logic signed [31:0] average;
        logic        has_data;
        logic        last_result;
    } t_out_item;

    // Work passed from front to back: a drop report or a completion pass.
    typedef struct packed {
        logic        drop;
        logic [1:0]  sid;
        logic [47:0] t;
        logic [47:0] wm;
    } t_job;
endpackage

FILE: rtl/twa_div.sv
// Signed 56 by 16 bit restoring divider, one quotient bit per cycle.
// Depends on twa_pkg.
`timescale 1ns / 1ps
module twa_div
    import twa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  logic signed [55:0] i_num,
    input  logic [15:0]        i_den,
    output logic               o_done,
    output logic signed [31:0] o_quo
);
    logic [55:0] r_q, n_q;
    logic [16:0] r_rem, n_rem;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_neg, n_neg, r_done, n_done;
    logic [15:0] r_den, n_den;
    logic [16:0] w_try;
    logic [55:0] w_qn;

    always_comb begin
        n_q = r_q; n_rem = r_rem; n_cnt = r_cnt; n_busy = r_busy;
        n_neg = r_neg; n_den = r_den; n_done = 1'b0;
        w_try = {r_rem[15:0], r_q[55]};
        if (i_go) begin
            n_q = i_num[55] ? 56'(-i_num) : i_num;
            n_neg = i_num[55];
            n_rem = '0; n_den = i_den; n_cnt = '0; n_busy = 1'b1;
        end else if (r_busy) begin
            n_q = {r_q[54:0], 1'b0};
            if (w_try >= {1'b0, r_den}) begin
                n_rem = w_try - {1'b0, r_den};
                n_q[0] = 1'b1;
            end else begin
                n_rem = w_try;
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd55) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_q <= n_q; r_rem <= n_rem; r_neg <= n_neg; r_den <= n_den;
    end

    always_comb begin
        w_qn = r_neg ? 56'(-r_q) : r_q;
    end
    assign o_done = r_done;
    assign o_quo  = w_qn[31:0];
endmodule

FILE: rtl/twa_front.sv
// Front: window table, slot assignment, sums/counts, watermarks.
// Depends on twa_pkg. Back side frees windows through i_free.
`timescale 1ns / 1ps
module twa_front
    import twa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_in_item    i_item,
    input  logic        i_stall,
    input  logic [31:0] i_len,
    input  logic [AVAL_W-1:0] i_act,
    output logic        o_busy,
    output logic        o_push,
    output t_job        o_job,
    // table view and release for the back part
    output logic [MAX_WIN-1:0] o_valid,
    output logic [MAX_WIN-1:0][47:0] o_begin,
    input  logic        i_free,
    input  logic [WIN_W-1:0] i_free_slot,
    input  logic [STR_W-1:0] i_rd_str,
    input  logic [WIN_W-1:0] i_rd_slot,
    output logic signed [55:0] o_rd_sum,
    output logic [15:0] o_rd_cnt
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001, S_DIV = 4'b0010, S_ACC = 4'b0100, S_PUSH = 4'b1000
    } t_fst;

    t_fst r_st, n_st;
    logic [MAX_WIN-1:0] r_valid;
    logic [MAX_WIN-1:0][47:0] r_begin;
    logic signed [55:0] r_sum [MAX_WIN*NUM_STR];
    logic [15:0] r_cnt [MAX_WIN*NUM_STR];
    logic [NUM_STR-1:0][47:0] r_wm;
    t_in_item r_it;
    logic [WIN_W-1:0] r_slot;
    logic [47:0] r_rem, r_quo;
    logic [5:0]  r_bit;
    logic        r_drop;
    logic [32:0] w_len;
    logic [WIN_W-1:0] w_free;
    logic        w_hit, w_any, w_prev, w_hasfree;
    logic [WIN_W-1:0] w_hslot;
    logic [47:0] w_pend;
    logic [48:0] w_e;
    logic [48:0] w_try;
    logic [47:0] w_min;
    logic [AVAL_W-1:0] w_act;
    logic [WIN_W+STR_W-1:0] w_idx;

    assign w_len = (i_len == 32'd0) ? 33'd1 : {1'b0, i_len};
    assign w_act = (i_act == '0) ? AVAL_W'(1) :
                   (i_act > AVAL_W'(NUM_STR)) ? AVAL_W'(NUM_STR) : i_act;

    // table scan: hit, latest preceding end, first free slot
    always_comb begin
        w_hit = 1'b0; w_any = 1'b0; w_prev = 1'b0; w_hasfree = 1'b0;
        w_hslot = '0; w_pend = '0; w_free = '0; w_e = '0;
        for (int i = 0; i < MAX_WIN; i++) begin
            w_e = {1'b0, r_begin[i]} + {16'd0, w_len};
            if (!r_valid[i]) begin
                if (!w_hasfree) begin
                    w_hasfree = 1'b1;
                    w_free = WIN_W'(i);
                end
            end else begin
                w_any = 1'b1;
                if (r_begin[i] <= i_item.event_time &&
                    {1'b0, i_item.event_time} < w_e && !w_hit) begin
                    w_hit = 1'b1;
                    w_hslot = WIN_W'(i);
                end
                if (w_e <= {1'b0, i_item.event_time} &&
                    (!w_prev || w_e[47:0] > w_pend)) begin
                    w_prev = 1'b1;
                    w_pend = w_e[47:0];
                end
            end
        end
    end

    // minimum active watermark after this item's update
    always_comb begin
        w_min = r_wm[0];
        for (int s = 1; s < NUM_STR; s++)
            if (AVAL_W'(s) < w_act && r_wm[s] < w_min) w_min = r_wm[s];
    end

    assign w_try = {r_rem, r_quo[47]};
    assign w_idx = {r_slot, r_it.stream_id};

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE:  if (i_start) n_st = S_PUSH;
            S_DIV:   if (r_bit == 6'd47) n_st = S_ACC;
            S_ACC:   n_st = S_PUSH;
            S_PUSH:  if (!i_stall && r_drop) n_st = S_IDLE;
                     else if (!i_stall) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
        if (r_st == S_IDLE && i_start) begin
            if (w_hit || !w_hasfree || !w_any || !w_prev) n_st = S_ACC;
            else n_st = S_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_valid <= '0;
            r_wm <= '0;
            for (int k = 0; k < MAX_WIN*NUM_STR; k++) begin
                r_sum[k] <= '0;
                r_cnt[k] <= '0;
            end
        end else begin
            r_st <= n_st;
            if (i_free) begin
                r_valid[i_free_slot] <= 1'b0;
                for (int s = 0; s < NUM_STR; s++) begin
                    r_sum[{i_free_slot, STR_W'(s)}] <= '0;
                    r_cnt[{i_free_slot, STR_W'(s)}] <= '0;
                end
            end
            case (r_st)
                S_IDLE: if (i_start) begin
                    r_it <= i_item;
                    r_drop <= 1'b0;
                    if (w_hit) r_slot <= w_hslot;
                    else begin
                        r_slot <= w_free;
                        if (!w_hasfree || (w_any && !w_prev)) r_drop <= 1'b1;
                        else if (!w_any) begin
                            r_begin[w_free] <= i_item.event_time;
                            r_valid[w_free] <= 1'b1;
                        end
                    end
                    // (t - prev_end) mod len, bit serial
                    r_quo  <= i_item.event_time - w_pend;
                    r_rem  <= '0;
                    r_bit  <= '0;
                end
                S_DIV: begin
                    r_bit <= r_bit + 6'd1;
                    if (w_try >= {16'd0, w_len}) begin
                        r_rem <= 48'(w_try - {16'd0, w_len});
                        r_quo <= {r_quo[46:0], 1'b1};
                    end else begin
                        r_rem <= w_try[47:0];
                        r_quo <= {r_quo[46:0], 1'b0};
                    end
                    // aligned begin is the time less the final remainder
                    if (r_bit == 6'd47) begin
                        r_valid[r_slot] <= 1'b1;
                        r_begin[r_slot] <= r_it.event_time -
                            ((w_try >= {16'd0, w_len}) ?
                             48'(w_try - {16'd0, w_len}) : w_try[47:0]);
                    end
                end
                S_ACC: if (!r_drop) begin
                    if (r_cnt[w_idx] != CNT_MAX) begin
                        r_cnt[w_idx] <= r_cnt[w_idx] + 16'd1;
                        r_sum[w_idx] <= r_sum[w_idx] + 56'(r_it.sample);
                    end
                    r_wm[r_it.stream_id] <= r_it.event_time;
                end
                default: ;
            endcase
        end
    end

    assign o_busy  = (r_st != S_IDLE);
    assign o_push  = (r_st == S_PUSH) && !i_stall;
    assign o_job.drop = r_drop;
    assign o_job.sid  = r_it.stream_id;
    assign o_job.t    = r_it.event_time;
    assign o_job.wm   = w_min;
    assign o_valid  = r_valid;
    assign o_begin  = r_begin;
    assign o_rd_sum = r_sum[{i_rd_slot, i_rd_str}];
    assign o_rd_cnt = r_cnt[{i_rd_slot, i_rd_str}];
endmodule

FILE: rtl/twa_back.sv
// Back: two-entry job queue, completes windows in begin order, divides.
// Depends on twa_pkg and twa_div.
`timescale 1ns / 1ps
module twa_back
    import twa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_job        i_job,
    output logic        o_full,
    output logic        o_idle,
    input  logic [31:0] i_len,
    input  logic [AVAL_W-1:0] i_act,
    input  logic [MAX_WIN-1:0] i_valid,
    input  logic [MAX_WIN-1:0][47:0] i_begin,
    output logic        o_free,
    output logic [WIN_W-1:0] o_free_slot,
    output logic [STR_W-1:0] o_rd_str,
    output logic [WIN_W-1:0] o_rd_slot,
    input  logic signed [55:0] i_rd_sum,
    input  logic [15:0] i_rd_cnt,
    output logic        o_res_vld,
    output t_out_item   o_res
);
    typedef enum logic [4:0] {
        B_IDLE = 5'b00001, B_SCAN = 5'b00010, B_DIV = 5'b00100,
        B_EMIT = 5'b01000, B_NEXT = 5'b10000
    } t_bst;

    t_bst r_st;
    t_job r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_n;
    t_job r_cur;
    logic [WIN_W-1:0] r_slot;
    logic [STR_W-1:0] r_s;
    logic [47:0] r_b;
    logic r_go, r_vld;
    t_out_item r_out;
    logic [32:0] w_len;
    logic [AVAL_W-1:0] w_act;
    logic w_found, w_done, w_lastwin;
    logic [WIN_W-1:0] w_best;
    logic [47:0] w_bb;
    logic [48:0] w_e;
    logic signed [31:0] w_quo;
    logic w_pop;

    assign w_len = (i_len == 32'd0) ? 33'd1 : {1'b0, i_len};
    assign w_act = (i_act == '0) ? AVAL_W'(1) :
                   (i_act > AVAL_W'(NUM_STR)) ? AVAL_W'(NUM_STR) : i_act;

    // oldest window whose end is at or below the watermark
    always_comb begin
        w_found = 1'b0; w_best = '0; w_bb = '0; w_e = '0;
        for (int i = 0; i < MAX_WIN; i++) begin
            w_e = {1'b0, i_begin[i]} + {16'd0, w_len};
            if (i_valid[i] && w_e <= {1'b0, r_cur.wm} &&
                (!w_found || i_begin[i] < w_bb)) begin
                w_found = 1'b1;
                w_best = WIN_W'(i);
                w_bb = i_begin[i];
            end
        end
    end

    twa_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(r_go),
        .i_num(i_rd_sum), .i_den(i_rd_cnt), .o_done(w_done), .o_quo(w_quo)
    );

    assign w_pop = (r_st == B_IDLE) && (r_n != 2'd0);
    assign w_lastwin = (3'({1'b0, r_s}) + 3'd1 == w_act);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= B_IDLE; r_wp <= 1'b0; r_rp <= 1'b0; r_n <= '0;
            r_go <= 1'b0; r_vld <= 1'b0;
        end else begin
            r_go <= 1'b0;
            r_vld <= 1'b0;
            if (i_push) begin
                r_q[r_wp] <= i_job;
                r_wp <= ~r_wp;
            end
            if (w_pop) r_rp <= ~r_rp;
            r_n <= r_n + (i_push ? 2'd1 : 2'd0) - (w_pop ? 2'd1 : 2'd0);
            case (r_st)
                B_IDLE: if (w_pop) begin
                    r_cur <= r_q[r_rp];
                    if (r_q[r_rp].drop) begin
                        r_vld <= 1'b1;
                        r_out <= '{KIND_DROP, r_q[r_rp].sid, r_q[r_rp].t, 48'd0,
                                   32'sd0, 1'b0, 1'b1};
                    end else begin
                        r_st <= B_SCAN;
                    end
                end
                B_SCAN: begin
                    if (w_found) begin
                        r_slot <= w_best; r_b <= w_bb; r_s <= '0;
                        r_st <= B_DIV; r_go <= 1'b1;
                    end else begin
                        r_st <= B_IDLE;
                    end
                end
                B_DIV: if (w_done) r_st <= B_EMIT;
                B_EMIT: begin
                    r_vld <= 1'b1;
                    r_out <= '{KIND_AVG, r_s, r_b, 48'(r_b + 48'(w_len)),
                               (i_rd_cnt == 16'd0) ? 32'sd0 : w_quo,
                               (i_rd_cnt != 16'd0), 1'b0};
                    r_st <= B_NEXT;
                end
                B_NEXT: begin
                    if (!w_lastwin) begin
                        r_s <= r_s + STR_W'(1);
                        r_go <= 1'b1;
                        r_st <= B_DIV;
                    end else begin
                        r_st <= B_SCAN;
                    end
                end
                default: r_st <= B_IDLE;
            endcase
        end
    end

    // free the window after its last stream; last flag known once scan misses
    assign o_free      = (r_st == B_NEXT) && w_lastwin;
    assign o_free_slot = r_slot;
    assign o_rd_slot   = r_slot;
    assign o_rd_str    = r_s;
    assign o_full      = (r_n == 2'd2);
    assign o_idle      = (r_st == B_IDLE) && (r_n == 2'd0);

    // hold one average so last_result can be set when the scan ends;
    // a drop report goes straight out and is never held
    t_out_item r_hold;
    logic      r_hvld;
    logic      w_end;
    assign w_end = (r_st == B_SCAN) && !w_found;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_hvld <= 1'b0;
        else if (r_vld && !r_out.last_result) r_hvld <= 1'b1;
        else if (w_end) r_hvld <= 1'b0;
        if (r_vld) r_hold <= r_out;
    end
    assign o_res_vld = (r_vld && r_hvld && !r_hold.last_result) ||
                       (w_end && r_hvld) ||
                       (r_vld && r_out.last_result && !r_hvld);
    always_comb begin
        o_res = r_hold;
        if (w_end) o_res.last_result = 1'b1;
        if (r_vld && r_out.last_result && !r_hvld) o_res = r_out;
    end
endmodule

FILE: rtl/tumbling_window_averager_core.sv
// Top level of the tumbling window averager: APB registers, front, back.
// Depends on twa_pkg, twa_front, twa_back, twa_div.
//
// Usage: pulse start with busy low to give one sample (stream, time,
// Q16.16 value). The front assigns it to a window, updates sums, counts and
// the stream watermark, then hands a job to the back through a two-entry
// queue. The back completes every open window whose end is at or below the
// minimum active watermark, oldest first, and emits one result per active
// stream. A dropped sample gives one result of kind 1; a sample that
// completes nothing gives no result.
// Per sample the front goes from idle through accumulate to push, which waits
// while the job queue is full; a 48-step bit-serial alignment division comes
// first when a new window is opened after an earlier one. Each completed
// window takes a scan, then per active stream a 56-step divide with its go and
// done, an emit and an advance. Results appear on o_result with o_result_valid for
// one cycle each and cannot be stalled; each average is held until the next
// result or the end of the scan so last_result can mark the final one of an item.
// Reset clears valid bits, sums, counts and watermarks at once; registers
// return to length 1000 and four active streams.
`timescale 1ns / 1ps
module tumbling_window_averager_core
    import twa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in_item    i_item,
    output logic        o_result_valid,
    output t_out_item   o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [31:0] r_len;
    logic [AVAL_W-1:0] r_act;
    logic w_fbusy, w_push, w_full, w_idle, w_free;
    t_job w_job;
    logic [MAX_WIN-1:0] w_valid;
    logic [MAX_WIN-1:0][47:0] w_begin;
    logic [WIN_W-1:0] w_fslot, w_rslot;
    logic [STR_W-1:0] w_rstr;
    logic signed [55:0] w_sum;
    logic [15:0] w_cnt;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= 32'd1000;
            r_act <= AVAL_W'(NUM_STR);
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_LEN: r_len <= pwdata;
                REG_ACT: r_act <= pwdata[AVAL_W-1:0];
                default: ;
            endcase
        end
    end
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ACT) ? {29'd0, r_act} : r_len;

    twa_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start && !busy),
        .i_item(i_item), .i_stall(w_full), .i_len(r_len), .i_act(r_act),
        .o_busy(w_fbusy), .o_push(w_push), .o_job(w_job),
        .o_valid(w_valid), .o_begin(w_begin), .i_free(w_free),
        .i_free_slot(w_fslot), .i_rd_str(w_rstr), .i_rd_slot(w_rslot),
        .o_rd_sum(w_sum), .o_rd_cnt(w_cnt)
    );

    twa_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_job(w_job),
        .o_full(w_full), .o_idle(w_idle), .i_len(r_len), .i_act(r_act),
        .i_valid(w_valid), .i_begin(w_begin), .o_free(w_free),
        .o_free_slot(w_fslot), .o_rd_str(w_rstr), .o_rd_slot(w_rslot),
        .i_rd_sum(w_sum), .i_rd_cnt(w_cnt),
        .o_res_vld(o_result_valid), .o_res(o_result)
    );

    // the table is shared, so one item is in flight at a time
    assign busy = w_fbusy || !w_idle;
endmodule

FILE: rtl/twa_checker.sv
// Port-level checker for the averager, bound to the top level.
// Depends on twa_pkg.
`timescale 1ns / 1ps
module twa_checker
    import twa_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input logic      o_result_valid,
    input t_out_item o_result
);
    // an accepted item always occupies the block next cycle
    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("accept without busy");
    // a drop is always the single, final result
    a_drop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.kind == KIND_DROP |-> o_result.last_result)
        else $error("drop not last");
    // no data means a zero average
    a_nodata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_result.has_data |-> o_result.average == 0)
        else $error("nonzero average without data");
    // results only while an item is in flight
    a_res_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy)) else $error("stray result");
endmodule

bind tumbling_window_averager_core twa_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_result_valid(o_result_valid), .o_result(o_result)
);

FILE: verif/tb_tumbling_window_averager_core.sv
// Self-checking testbench for tumbling_window_averager_core: a clocked driver
// and monitor with an in-bench window/watermark predictor. Needs twa_pkg and the RTL.
`timescale 1ns / 1ps
module tb_tumbling_window_averager_core;
    import twa_pkg::*;

    localparam int          LIMIT_CYCLES = 6000000;
    localparam int          SETTLE       = 300;
    localparam logic [2:0]  ADDR_LEN     = 3'(4 * REG_LEN);
    localparam logic [2:0]  ADDR_ACT     = 3'(4 * REG_ACT);
    localparam logic [47:0] TMAX         = 48'hFFFF_FFFF_FFFF;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_in_item    i_item = '0;
    logic        o_result_valid;
    t_out_item   o_result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    tumbling_window_averager_core u_top (
        .i_clk, .i_rst_n, .start, .busy, .i_item, .o_result_valid, .o_result,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    always #2 i_clk = ~i_clk;

    // Predictor state
    logic [31:0]  win_len_cfg;
    logic [2:0]   act_cfg;
    logic [47:0]  win_begin [MAX_WIN];
    bit           win_open  [MAX_WIN];
    longint       win_sum   [MAX_WIN*NUM_STR];
    int unsigned  win_cnt   [MAX_WIN*NUM_STR];
    logic [47:0]  watermark [NUM_STR];

    t_in_item  pending_items[$];
    t_out_item expected_avgs[$];
    int        idle_pct = 0;
    int        n_items = 0, n_results = 0, n_drops = 0, n_errors = 0;
    longint    cycles = 0;
    logic [47:0] now_t = '0;

    // Window assignment, accumulation and completion for one accepted sample
    function automatic void predict_sample(t_in_item it);
        logic [63:0] len, t, prev_end, e, wm;
        int          slot, free_slot, best, idx, act, n;
        bit          any, have_prev;
        longint      avg;
        t_out_item   r;
        len = (win_len_cfg == 0) ? 64'd1 : 64'(win_len_cfg);
        act = (act_cfg == 0) ? 1 : (act_cfg > NUM_STR) ? NUM_STR : int'(act_cfg);
        t = 64'(it.event_time);
        slot = -1;
        free_slot = -1;
        any = 0;
        have_prev = 0;
        prev_end = 0;
        for (int i = 0; i < MAX_WIN; i++) begin
            if (!win_open[i]) begin
                if (free_slot < 0) free_slot = i;
            end else if (slot < 0) begin
                any = 1;
                e = 64'(win_begin[i]) + len;
                if (64'(win_begin[i]) <= t && t < e) slot = i;
                else if (e <= t && (!have_prev || e > prev_end)) begin
                    prev_end = e;
                    have_prev = 1;
                end
            end
        end
        if (slot < 0 && free_slot >= 0) begin
            if (!any) begin
                slot = free_slot;
                win_begin[slot] = t[47:0];
            end else if (have_prev) begin
                slot = free_slot;
                win_begin[slot] = 48'(prev_end + ((t - prev_end) / len) * len);
            end
            if (slot >= 0) win_open[slot] = 1;
        end
        // early sample or full table: one drop report, no state change
        if (slot < 0) begin
            r = '0;
            r.kind = KIND_DROP;
            r.out_stream = it.stream_id;
            r.window_begin = it.event_time;
            r.last_result = 1'b1;
            expected_avgs = {expected_avgs, r};
            return;
        end
        idx = slot * NUM_STR + int'(it.stream_id);
        if (win_cnt[idx] < CNT_MAX) begin
            win_cnt[idx]++;
            win_sum[idx] += longint'($signed(it.sample));
        end
        watermark[it.stream_id] = it.event_time;
        wm = 64'(watermark[0]);
        for (int s = 1; s < act; s++)
            if (64'(watermark[s]) < wm) wm = 64'(watermark[s]);
        // complete windows oldest first
        n = 0;
        forever begin
            best = -1;
            for (int i = 0; i < MAX_WIN; i++) begin
                if (win_open[i] && 64'(win_begin[i]) + len <= wm &&
                    (best < 0 || win_begin[i] < win_begin[best])) best = i;
            end
            if (best < 0) break;
            for (int s = 0; s < act; s++) begin
                idx = best * NUM_STR + s;
                avg = (win_cnt[idx] != 0) ? win_sum[idx] / longint'(win_cnt[idx]) : 0;
                r = '0;
                r.kind = KIND_AVG;
                r.out_stream = 2'(s);
                r.window_begin = win_begin[best];
                r.window_end = 48'(64'(win_begin[best]) + len);
                r.average = avg[31:0];
                r.has_data = (win_cnt[idx] != 0);
                expected_avgs = {expected_avgs, r};
                n++;
            end
            for (int s = 0; s < NUM_STR; s++) begin
                win_cnt[best*NUM_STR + s] = 0;
                win_sum[best*NUM_STR + s] = 0;
            end
            win_open[best] = 0;
        end
        if (n > 0) expected_avgs[expected_avgs.size()-1].last_result = 1'b1;
    endfunction

    // Driver: hold start until accepted, random idle gaps between items
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                predict_sample(i_item);
                n_items++;
            end
            if (!start || !busy) begin
                if (pending_items.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                    start <= 1'b1;
                    i_item <= pending_items.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_out_item x;
        if (i_rst_n && o_result_valid) begin
            n_results++;
            if (expected_avgs.size() == 0) begin
                $error("unexpected result %p", o_result);
                n_errors++;
            end else begin
                x = expected_avgs.pop_front();
                if (o_result.kind == KIND_DROP) n_drops++;
                if (o_result.kind !== x.kind) begin
                    $error("kind exp %0d got %0d", x.kind, o_result.kind);
                    n_errors++;
                end
                if (o_result.out_stream !== x.out_stream) begin
                    $error("out_stream exp %0d got %0d", x.out_stream, o_result.out_stream);
                    n_errors++;
                end
                if (o_result.window_begin !== x.window_begin) begin
                    $error("window_begin exp %h got %h", x.window_begin, o_result.window_begin);
                    n_errors++;
                end
                if (o_result.window_end !== x.window_end) begin
                    $error("window_end exp %h got %h", x.window_end, o_result.window_end);
                    n_errors++;
                end
                if (o_result.average !== x.average) begin
                    $error("average exp %h got %h", x.average, o_result.average);
                    n_errors++;
                end
                if (o_result.has_data !== x.has_data) begin
                    $error("has_data exp %0d got %0d", x.has_data, o_result.has_data);
                    n_errors++;
                end
                if (o_result.last_result !== x.last_result) begin
                    $error("last_result exp %0d got %0d", x.last_result, o_result.last_result);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("tumbling_window_averager_core verification failed");
            $finish;
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_LEN) win_len_cfg = data;
        else act_cfg = data[2:0];
    endtask

    task automatic add_item(input logic [1:0] sid, input logic [47:0] t,
                            input logic [31:0] v);
        t_in_item it;
        it.stream_id = sid;
        it.event_time = t;
        it.sample = v;
        pending_items = {pending_items, it};
    endtask

    // Wait until every queued item is taken and every result is back
    task automatic drain();
        while (pending_items.size() > 0 || start || expected_avgs.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Mostly in-order traffic around a moving time, with late and far-ahead noise
    task automatic random_traffic(input int count);
        logic [63:0] len, t, lag;
        logic [31:0] v;
        int          mode;
        len = (win_len_cfg == 0) ? 64'd1 : 64'(win_len_cfg);
        for (int k = 0; k < count; k++) begin
            mode = $urandom_range(0, 99);
            now_t = now_t + 48'($urandom_range(0, 32'(len > 64'd600 ? 600 : len)) *
                                (len > 64'd600 ? len / 600 : 64'd1) / 2);
            lag = 64'($urandom_range(0, 3));
            if (mode < 80) t = (64'(now_t) > lag) ? 64'(now_t) - lag : 64'(now_t);
            else if (mode < 92) t = 64'(now_t) - 64'(now_t) / 64'($urandom_range(1, 4));
            else t = 64'(now_t) + len * 64'($urandom_range(0, 12));
            case ($urandom_range(0, 9))
                0: v = 32'h8000_0000;
                1: v = 32'h7FFF_FFFF;
                default: v = $urandom;
            endcase
            add_item(2'($urandom_range(0, NUM_STR-1)), t[47:0], v);
        end
    endtask

    initial begin
        foreach (win_open[i]) begin
            win_open[i] = 0;
            win_begin[i] = '0;
        end
        foreach (win_sum[i]) begin
            win_sum[i] = 0;
            win_cnt[i] = 0;
        end
        foreach (watermark[i]) watermark[i] = '0;
        win_len_cfg = 32'd1000;
        act_cfg = 3'd4;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: first window, early drop, extreme values, table full
        add_item(2'd0, 48'd500, 32'h7FFF_FFFF);
        add_item(2'd3, 48'd100, 32'h8000_0000);
        add_item(2'd3, 48'd900, 32'h8000_0000);
        add_item(2'd2, 48'd1499, 32'hFFFF_FFFF);
        for (int s = 0; s < NUM_STR; s++) add_item(2'(s), 48'd1600, 32'h0001_0000);
        for (int k = 0; k < 9; k++) add_item(2'd0, 48'(2600 + 1000 * k), $urandom);
        add_item(2'd1, 48'd1550, 32'h0000_0001);
        for (int s = 1; s < NUM_STR; s++) add_item(2'(s), 48'd20000, 32'h8000_0001);
        add_item(2'd0, 48'd20000, 32'h0);
        drain();

        // Random phases over several register settings and idle levels
        reg_write(ADDR_LEN, 32'd1000); reg_write(ADDR_ACT, 32'd4);
        idle_pct = 0;  random_traffic(80);  drain();
        reg_write(ADDR_LEN, 32'd7);    reg_write(ADDR_ACT, 32'd2);
        idle_pct = 56; random_traffic(80);  drain();
        reg_write(ADDR_LEN, 32'd0);    reg_write(ADDR_ACT, 32'd0);
        idle_pct = 24; random_traffic(60);  drain();
        reg_write(ADDR_LEN, 32'd13);   reg_write(ADDR_ACT, 32'd7);
        idle_pct = 56; random_traffic(60);  drain();
        reg_write(ADDR_LEN, 32'hFFFF_FFFF); reg_write(ADDR_ACT, 32'd3);
        idle_pct = 0;  random_traffic(60);  drain();
        reg_write(ADDR_LEN, 32'd250);  reg_write(ADDR_ACT, 32'd1);
        idle_pct = 24; random_traffic(60);  drain();

        // Top of the time range: window end past 48 bits, then flush with length 1
        idle_pct = 0;
        reg_write(ADDR_LEN, 32'hFFFF_FFFF); reg_write(ADDR_ACT, 32'd4);
        for (int s = 0; s < NUM_STR; s++) add_item(2'(s), TMAX - 48'd5, $urandom);
        add_item(2'd2, TMAX, 32'h8000_0000);
        drain();
        reg_write(ADDR_LEN, 32'd1);
        for (int s = 0; s < NUM_STR; s++) add_item(2'(s), TMAX, $urandom);
        drain();

        $display("%0d items accepted, %0d results checked (%0d drop reports)",
                 n_items, n_results, n_drops);
        $display("window lengths 0..max, active counts 0..7, idle 0/24/56 percent");
        if (n_errors == 0 && expected_avgs.size() == 0) begin
            $display("tumbling_window_averager_core verification clean");
        end else begin
            $display("tumbling_window_averager_core verification failed");
        end
        $finish;
    end
endmodule
